[rtl/lfu_pkg.sv]
// Shared types and constants for the LFU cache.
`timescale 1ns / 1ps
package lfu_pkg;

	localparam int SLOTS     = 16;
	localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int CAP_W     = 5;
	localparam int KEY_W     = 32;
	localparam int DATA_W    = 32;
	localparam int USE_W     = 16;
	localparam int STAMP_W   = 32;
	localparam int CAP_RESET = 16;

	localparam logic [USE_W-1:0]   USE_MAX   = '1;
	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [DATA_W-1:0]  data;
		logic [USE_W-1:0]   count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   match_idx;
		logic [DATA_W-1:0]  match_data;
		logic [USE_W-1:0]   match_count;
		logic               have_free;
		logic [IDX_W-1:0]   free_idx;
		logic [IDX_W-1:0]   victim_idx;
	} scan_res_t;

endpackage

[rtl/lfu_slot_mem.sv]
// Slot store: key, data, use count and touch stamp per slot, registered read.
`timescale 1ns / 1ps
module lfu_slot_mem (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [lfu_pkg::IDX_W-1:0] wr_addr,
	input  lfu_pkg::entry_t       wr_data,
	input  logic [lfu_pkg::IDX_W-1:0] rd_addr,
	output lfu_pkg::entry_t       rd_data
);

	lfu_pkg::entry_t mem_q [lfu_pkg::SLOTS];
	lfu_pkg::entry_t rd_data_q;

	// Write one slot
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one slot; the data is registered and appears on the next cycle
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/lfu_scan.sv]
// Shared compare unit: key match, first free slot and victim tracking over a scan.
`timescale 1ns / 1ps
module lfu_scan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  logic                      step,
	input  logic [lfu_pkg::IDX_W-1:0] idx,
	input  logic                      slot_vld,
	input  lfu_pkg::entry_t           entry,
	input  logic [lfu_pkg::KEY_W-1:0] key,
	output lfu_pkg::scan_res_t        res
);

	logic                        found_q;
	logic [lfu_pkg::IDX_W-1:0]   match_idx_q;
	logic [lfu_pkg::DATA_W-1:0]  match_data_q;
	logic [lfu_pkg::USE_W-1:0]   match_count_q;
	logic                        free_q;
	logic [lfu_pkg::IDX_W-1:0]   free_idx_q;
	logic                        victim_q;
	logic [lfu_pkg::IDX_W-1:0]   victim_idx_q;
	logic [lfu_pkg::USE_W-1:0]   victim_count_q;
	logic [lfu_pkg::STAMP_W-1:0] victim_stamp_q;

	logic key_eq;
	logic better;

	// Compare the current slot against the request and the best victim so far
	assign key_eq = (entry.key == key);
	assign better = !victim_q || (entry.count < victim_count_q) ||
		((entry.count == victim_count_q) && (entry.stamp < victim_stamp_q));

	// Track flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			free_q   <= 1'b0;
			victim_q <= 1'b0;
		end else if (clear) begin
			found_q  <= 1'b0;
			free_q   <= 1'b0;
			victim_q <= 1'b0;
		end else if (step) begin
			if (slot_vld) begin
				if (!found_q && key_eq) begin
					found_q <= 1'b1;
				end
				if (better) begin
					victim_q <= 1'b1;
				end
			end else begin
				free_q <= 1'b1;
			end
		end
	end

	// Capture slot indexes and the fields that the update needs
	always_ff @(posedge clk) begin
		if (step) begin
			if (slot_vld) begin
				if (!found_q && key_eq) begin
					match_idx_q   <= idx;
					match_data_q  <= entry.data;
					match_count_q <= entry.count;
				end
				if (better) begin
					victim_idx_q   <= idx;
					victim_count_q <= entry.count;
					victim_stamp_q <= entry.stamp;
				end
			end else if (!free_q) begin
				free_idx_q <= idx;
			end
		end
	end

	assign res.found       = found_q;
	assign res.match_idx   = match_idx_q;
	assign res.match_data  = match_data_q;
	assign res.match_count = match_count_q;
	assign res.have_free   = free_q;
	assign res.free_idx    = free_idx_q;
	assign res.victim_idx  = victim_idx_q;

endmodule

[rtl/lfu_cache.sv]
// LFU cache top level: sequencer, valid flags, touch clock and response register.
// A request walks the slots in scan, then takes one read drain and one update in done;
// the scan covers n slots, where n is the capacity capped at 16, and is skipped at capacity 0.
// The single slot read port is walked one slot per cycle during the scan, and no new
// request is taken until the sequencer is back in idle; a response stall holds it in done.
// Reset clears valid flags, touch clock and sequencer at once; capacity resets to 16.
// Slot contents are not cleared and are read only behind their valid flags.
`timescale 1ns / 1ps
module lfu_cache (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [lfu_pkg::CAP_W-1:0]      cfg_wr_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           req_type,
	input  logic [lfu_pkg::KEY_W-1:0]      key,
	input  logic [lfu_pkg::DATA_W-1:0]     value,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic                           hit,
	output logic [lfu_pkg::DATA_W-1:0]     read_data,
	output logic                           evicted
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                   state_q;
	logic [lfu_pkg::CAP_W-1:0]    cap_q;
	logic [lfu_pkg::CNT_W-1:0]    cnt_q;
	logic [lfu_pkg::SLOTS-1:0]    valid_q;
	logic [lfu_pkg::STAMP_W-1:0]  clock_q;
	logic                         cmp_vld_q;
	logic [lfu_pkg::IDX_W-1:0]    cmp_idx_q;
	logic                         req_put_q;
	logic [lfu_pkg::KEY_W-1:0]    req_key_q;
	logic [lfu_pkg::DATA_W-1:0]   req_value_q;
	logic                         rsp_valid_q;
	logic                         hit_q;
	logic [lfu_pkg::DATA_W-1:0]   read_data_q;
	logic                         evicted_q;

	logic [lfu_pkg::CNT_W-1:0]    used;
	logic                         req_take;
	logic                         rsp_free;
	logic                         finish;
	logic                         upd_en;
	logic [lfu_pkg::IDX_W-1:0]    target;
	lfu_pkg::entry_t              wr_entry;
	lfu_pkg::entry_t              rd_entry;
	lfu_pkg::scan_res_t           scan_res;
	logic [lfu_pkg::USE_W-1:0]    count_next;

	// Slots to scan: the capacity, capped at the store depth
	assign used = (32'(cap_q) > 32'(lfu_pkg::SLOTS)) ?
		lfu_pkg::CNT_W'(lfu_pkg::SLOTS) : lfu_pkg::CNT_W'(cap_q);

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign finish    = (state_q == ST_DONE) && rsp_free;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfu_pkg::CAP_W'(lfu_pkg::CAP_RESET);
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// Sequencer: accept, walk the slots, drain the read, update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cmp_vld_q <= 1'b0;
					if (req_take) begin
						cnt_q   <= '0;
						state_q <= (used == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_q <= 1'b1;
					cnt_q     <= cnt_q + lfu_pkg::CNT_W'(1);
					if (cnt_q == used - lfu_pkg::CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					cmp_vld_q <= 1'b0;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					cmp_vld_q <= 1'b0;
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					cmp_vld_q <= 1'b0;
					state_q   <= ST_IDLE;
				end
			endcase
		end
	end

	// Track which slot's read data arrives next cycle
	always_ff @(posedge clk) begin
		cmp_idx_q <= cnt_q[lfu_pkg::IDX_W-1:0];
	end

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (req_take) begin
			req_put_q   <= req_type;
			req_key_q   <= key;
			req_value_q <= value;
		end
	end

	lfu_slot_mem u_mem (
		.clk     (clk),
		.wr_en   (upd_en),
		.wr_addr (target),
		.wr_data (wr_entry),
		.rd_addr (cnt_q[lfu_pkg::IDX_W-1:0]),
		.rd_data (rd_entry)
	);

	lfu_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (req_take),
		.step     (cmp_vld_q),
		.idx      (cmp_idx_q),
		.slot_vld (valid_q[cmp_idx_q]),
		.entry    (rd_entry),
		.key      (req_key_q),
		.res      (scan_res)
	);

	// Pick the slot to write and build the new entry
	assign count_next = (scan_res.match_count == lfu_pkg::USE_MAX) ?
		scan_res.match_count : scan_res.match_count + lfu_pkg::USE_W'(1);

	always_comb begin
		upd_en         = 1'b0;
		target         = scan_res.victim_idx;
		wr_entry.key   = req_key_q;
		wr_entry.data  = req_value_q;
		wr_entry.count = lfu_pkg::USE_W'(1);
		wr_entry.stamp = clock_q;
		priority if (scan_res.found) begin
			upd_en         = finish;
			target         = scan_res.match_idx;
			wr_entry.count = count_next;
			if (req_put_q == lfu_pkg::REQ_GET) begin
				wr_entry.data = scan_res.match_data;
			end
		end else if ((req_put_q == lfu_pkg::REQ_PUT) && (used != '0)) begin
			upd_en = finish;
			if (scan_res.have_free) begin
				target = scan_res.free_idx;
			end
		end else begin
			upd_en = 1'b0;
		end
	end

	// Mark written slots valid and advance the touch clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			clock_q <= '0;
		end else if (upd_en) begin
			valid_q[target] <= 1'b1;
			if (clock_q != lfu_pkg::STAMP_MAX) begin
				clock_q <= clock_q + lfu_pkg::STAMP_W'(1);
			end
		end
	end

	// Response valid: set on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q       <= scan_res.found;
			read_data_q <= (scan_res.found && (req_put_q == lfu_pkg::REQ_GET)) ?
				scan_res.match_data : '0;
			evicted_q   <= !scan_res.found && (req_put_q == lfu_pkg::REQ_PUT) &&
				(used != '0) && !scan_res.have_free;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;
	assign read_data = read_data_q;
	assign evicted   = evicted_q;

endmodule
